>>> hdl/tfem_pkg.sv
// Shared types and constants for the trace fit error metrics block.
`timescale 1ns / 1ps
package tfem_pkg;

    localparam int VALUE_W    = 32;
    localparam int SUM_W      = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int WAIT_W     = 16;
    localparam int MODE_W     = 2;

    localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FIT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ACTION_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_SAMPLES    = 2'd2;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ERR,
        OP_MUL,
        OP_FOUR,
        OP_ACC,
        OP_ACC2,
        OP_DIV_L1,
        OP_DIV_SQ,
        OP_DIV_FO,
        OP_ROOT_Q,
        OP_ROOT_S,
        OP_KEEP_L1,
        OP_KEEP_RMS,
        OP_KEEP_S,
        OP_KEEP_L4
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic fit;
        logic last;
        logic has_n;
        logic div_done;
        logic root_done;
    } t_sts;

endpackage

>>> hdl/tfem_in_if.sv
// Input channel: one due sample per transaction.
`timescale 1ns / 1ps
interface tfem_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tfem_pkg::VALUE_W-1:0]  target_value;
    logic signed [tfem_pkg::VALUE_W-1:0]  trace_value;
    logic                                 last_sample;

    modport source (output valid, target_value, trace_value, last_sample, input ready);
    modport sink   (input valid, target_value, trace_value, last_sample, output ready);
endinterface

>>> hdl/tfem_out_if.sv
// Output channel: one result per transaction.
`timescale 1ns / 1ps
interface tfem_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tfem_pkg::VALUE_W-1:0]  new_target;
    logic signed [tfem_pkg::VALUE_W-1:0]  error_value;
    logic                                 alter_model;
    logic                                 metrics_valid;
    logic [tfem_pkg::VALUE_W-1:0]         rms_error;
    logic [tfem_pkg::VALUE_W-1:0]         max_error;
    logic [tfem_pkg::VALUE_W-1:0]         l4_error;
    logic [tfem_pkg::VALUE_W-1:0]         l1_error;

    modport source (output valid, new_target, error_value, alter_model, metrics_valid,
                    rms_error, max_error, l4_error, l1_error, input ready);
    modport sink   (input valid, new_target, error_value, alter_model, metrics_valid,
                    rms_error, max_error, l4_error, l1_error, output ready);
endinterface

>>> hdl/trace_fit_error_metrics.sv
// Top level of the trace fit error metrics block.
// An ordinary sample runs through the error, multiply, fourth-power and accumulate steps; a new
//   sample is taken only once the previous result has been loaded into the output register.
// Last sample of a fit run: three 64-step divisions and three 32-step square roots follow,
//   all on one shared divider and one shared root unit.
// Reset (synchronous, active low) clears config registers, run state and output valid.
`timescale 1ns / 1ps
module trace_fit_error_metrics #(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tfem_in_if.sink                             i_in_ch,
    tfem_out_if.source                          o_out_ch,
    input  logic                                i_cfg_we,
    input  logic [tfem_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tfem_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    tfem_pkg::t_cmd cmd;
    tfem_pkg::t_sts sts;

    // Controller: takes one transaction at a time, walks the datapath through
    // error, multiply, fourth-power and accumulate steps, then on the last fit
    // sample runs the divide/root sequence before loading the output register.
    tfem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .o_in_ready  (i_in_ch.ready),
        .i_out_ready (o_out_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: holds config, the sample, run accumulators and the output register.
    tfem_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_target_value  (i_in_ch.target_value),
        .i_trace_value   (i_in_ch.trace_value),
        .i_last_sample   (i_in_ch.last_sample),
        .o_new_target    (o_out_ch.new_target),
        .o_error_value   (o_out_ch.error_value),
        .o_alter_model   (o_out_ch.alter_model),
        .o_metrics_valid (o_out_ch.metrics_valid),
        .o_rms_error     (o_out_ch.rms_error),
        .o_max_error     (o_out_ch.max_error),
        .o_l4_error      (o_out_ch.l4_error),
        .o_l1_error      (o_out_ch.l1_error)
    );
endmodule

>>> hdl/tfem_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tfem_div #(
    parameter int DIVISOR_W = 21
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tfem_pkg::SUM_W-1:0]    i_dividend,
    input  logic [DIVISOR_W-1:0]          i_divisor,
    output logic                          o_done,
    output logic [tfem_pkg::SUM_W-1:0]    o_quotient
);
    localparam int CNT_W = $clog2(tfem_pkg::SUM_W);

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [tfem_pkg::SUM_W-1:0]   r_q;
    logic [DIVISOR_W-1:0]         r_rem;
    logic [DIVISOR_W-1:0]         r_dv;
    logic [DIVISOR_W:0]           shifted;
    logic                         take;

    assign shifted = {r_rem, r_q[tfem_pkg::SUM_W-1]};
    assign take    = (shifted >= {1'b0, r_dv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(tfem_pkg::SUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[tfem_pkg::SUM_W-2:0], take};
            r_rem <= take ? DIVISOR_W'(shifted - {1'b0, r_dv}) : shifted[DIVISOR_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

>>> hdl/tfem_root.sv
// Digit-by-digit integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module tfem_root (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tfem_pkg::SUM_W-1:0]    i_radicand,
    output logic                          o_done,
    output logic [tfem_pkg::VALUE_W-1:0]  o_root
);
    localparam int RW    = tfem_pkg::VALUE_W;
    localparam int CNT_W = $clog2(RW);
    localparam int REM_W = RW + 3;

    logic                         r_busy;
    logic                         r_done;
    logic [CNT_W-1:0]             r_cnt;
    logic [tfem_pkg::SUM_W-1:0]   r_x;
    logic [REM_W-1:0]             r_rem;
    logic [RW-1:0]                r_root;
    logic [REM_W-1:0]             rem_s;
    logic [REM_W-1:0]             trial;
    logic                         take;

    assign rem_s = {r_rem[REM_W-3:0], r_x[tfem_pkg::SUM_W-1 -: 2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign take  = (rem_s >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(RW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[tfem_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= take ? (rem_s - trial) : rem_s;
            r_root <= {r_root[RW-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

>>> hdl/tfem_dp.sv
// Datapath: config registers, error and correction math, run accumulators, metrics.
`timescale 1ns / 1ps
module tfem_dp #(
    parameter int MAX_SAMPLES = 1048576
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tfem_pkg::t_cmd                         i_cmd,
    output tfem_pkg::t_sts                         o_sts,
    input  logic                                   i_cfg_we,
    input  logic [tfem_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tfem_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [tfem_pkg::VALUE_W-1:0]    i_target_value,
    input  logic signed [tfem_pkg::VALUE_W-1:0]    i_trace_value,
    input  logic                                   i_last_sample,
    output logic signed [tfem_pkg::VALUE_W-1:0]    o_new_target,
    output logic signed [tfem_pkg::VALUE_W-1:0]    o_error_value,
    output logic                                   o_alter_model,
    output logic                                   o_metrics_valid,
    output logic [tfem_pkg::VALUE_W-1:0]           o_rms_error,
    output logic [tfem_pkg::VALUE_W-1:0]           o_max_error,
    output logic [tfem_pkg::VALUE_W-1:0]           o_l4_error,
    output logic [tfem_pkg::VALUE_W-1:0]           o_l1_error
);
    localparam int VW = tfem_pkg::VALUE_W;
    localparam int SW = tfem_pkg::SUM_W;
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] a, input logic [SW-1:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SW] ? '1 : s[SW-1:0];
    endfunction

    // configuration
    logic [tfem_pkg::MODE_W-1:0] r_mode;
    logic [tfem_pkg::GAIN_W-1:0] r_gain;
    logic [tfem_pkg::WAIT_W-1:0] r_wait;

    // sample
    logic signed [VW-1:0] r_target, r_trace;
    logic                 r_last, r_fit, r_clamp, r_corr_en;

    // per-sample math
    logic signed [VW-1:0] r_err;
    logic [VW-1:0]        r_mag;
    logic [SW-1:0]        r_sq;
    logic signed [48:0]   r_prod;
    logic [SW-1:0]        r_ll;
    logic [47:0]          r_hl;
    logic [31:0]          r_hh;
    logic                 r_hi_big;
    logic signed [VW-1:0] r_new;
    logic [SW-1:0]        r_four_term;

    // run state
    logic [SW-1:0]                r_abs_sum, r_sq_sum, r_four_sum;
    logic [VW-1:0]                r_peak;
    logic [CW-1:0]                r_count;
    logic [tfem_pkg::WAIT_W-1:0]  r_waited;

    // metrics
    logic [VW-1:0] r_l1, r_rms, r_l4, r_s;

    // output register
    logic signed [VW-1:0] r_o_new, r_o_err;
    logic                 r_o_alter, r_o_mval;
    logic [VW-1:0]        r_o_rms, r_o_max, r_o_l4, r_o_l1;

    // combinational terms
    logic signed [VW:0]   diff;
    logic signed [VW-1:0] err_sat;
    logic [VW-1:0]        mag;
    logic signed [49:0]   psum;
    logic signed [33:0]   corr;
    logic signed [34:0]   newt_w;
    logic signed [VW-1:0] newt_sat;
    logic [65:0]          four_w;
    logic [SW-1:0]        four_t;
    logic                 run_clear;

    logic                 div_start, root_start, div_done, root_done;
    logic [SW-1:0]        dividend, radicand, quotient;
    logic [VW-1:0]        root;

    always_comb begin
        diff    = {r_target[VW-1], r_target} - {r_trace[VW-1], r_trace};
        err_sat = (diff[VW] != diff[VW-1]) ? (diff[VW] ? {1'b1, {(VW-1){1'b0}}}
                                                       : {1'b0, {(VW-1){1'b1}}})
                                           : diff[VW-1:0];
        mag     = err_sat[VW-1] ? (~err_sat + 1'b1) : err_sat;

        // round half up, then drop the 16 fraction bits of the gain
        psum   = {r_prod[48], r_prod} + 50'sd32768;
        corr   = psum[49:16];
        newt_w = {{3{r_target[VW-1]}}, r_target} - {corr[33], corr};
        newt_sat = (newt_w[34:31] != 4'b0000 && newt_w[34:31] != 4'b1111)
                   ? (newt_w[34] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                   : newt_w[VW-1:0];

        // fourth power term: (sq * sq) >> 32, saturating
        four_w = {2'b00, r_hh, 32'd0} + {17'd0, r_hl, 1'b0} + {34'd0, r_ll[63:32]};
        four_t = (r_hi_big || four_w[65:64] != 2'b00) ? '1 : four_w[SW-1:0];
    end

    assign run_clear = i_cmd.out_load && r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tfem_pkg::MODE_RECORD;
            r_gain <= '0;
            r_wait <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfem_pkg::REG_ACTION_MODE:     r_mode <= i_cfg_data[tfem_pkg::MODE_W-1:0];
                tfem_pkg::REG_CORRECTION_GAIN: r_gain <= i_cfg_data[tfem_pkg::GAIN_W-1:0];
                tfem_pkg::REG_WAIT_SAMPLES:    r_wait <= i_cfg_data[tfem_pkg::WAIT_W-1:0];
                default: ;
            endcase
        end
    end

    // run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || run_clear) begin
            r_abs_sum  <= '0;
            r_sq_sum   <= '0;
            r_four_sum <= '0;
            r_peak     <= '0;
            r_count    <= '0;
            r_waited   <= '0;
        end else begin
            case (i_cmd.op)
                tfem_pkg::OP_ERR: begin
                    if (r_fit && r_waited < r_wait) r_waited <= r_waited + 1'b1;
                end
                tfem_pkg::OP_ACC: begin
                    if (r_fit) begin
                        r_abs_sum <= sat_add(r_abs_sum, {{(SW-VW){1'b0}}, r_mag});
                        r_sq_sum  <= sat_add(r_sq_sum, r_sq);
                        if (r_mag > r_peak) r_peak <= r_mag;
                        if (r_count < CW'(MAX_SAMPLES)) r_count <= r_count + 1'b1;
                    end
                end
                tfem_pkg::OP_ACC2: begin
                    if (r_fit) r_four_sum <= sat_add(r_four_sum, r_four_term);
                end
                default: ;
            endcase
        end
    end

    // sample payload and per-sample math
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_target <= i_target_value;
            r_trace  <= i_trace_value;
            r_last   <= i_last_sample;
            r_fit    <= (r_mode == tfem_pkg::MODE_FIT);
            r_clamp  <= (r_mode == tfem_pkg::MODE_CLAMP);
        end
        case (i_cmd.op)
            tfem_pkg::OP_ERR: begin
                r_err     <= r_fit ? err_sat : '0;
                r_mag     <= r_fit ? mag : '0;
                r_corr_en <= !(r_waited < r_wait);
                r_l1      <= '0;
                r_rms     <= '0;
                r_l4      <= '0;
            end
            tfem_pkg::OP_MUL: begin
                r_sq   <= r_mag * r_mag;
                r_prod <= r_err * $signed({1'b0, r_gain});
            end
            tfem_pkg::OP_FOUR: begin
                r_ll     <= r_sq[31:0] * r_sq[31:0];
                r_hl     <= r_sq[47:32] * r_sq[31:0];
                r_hh     <= r_sq[47:32] * r_sq[47:32];
                r_hi_big <= (r_sq[63:48] != 16'd0);
                if (r_clamp)                r_new <= r_trace;
                else if (r_fit && r_corr_en) r_new <= newt_sat;
                else                        r_new <= r_target;
            end
            tfem_pkg::OP_ACC:      r_four_term <= four_t;
            tfem_pkg::OP_KEEP_L1:  r_l1  <= quotient[VW-1:0];
            tfem_pkg::OP_KEEP_RMS: r_rms <= root;
            tfem_pkg::OP_KEEP_S:   r_s   <= root;
            tfem_pkg::OP_KEEP_L4:  r_l4  <= root;
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_o_new   <= r_new;
            r_o_err   <= r_err;
            r_o_alter <= r_fit || r_clamp;
            r_o_mval  <= r_last;
            r_o_rms   <= r_rms;
            r_o_l4    <= r_l4;
            r_o_l1    <= r_l1;
            r_o_max   <= (r_last && r_fit && r_count != '0) ? r_peak : '0;
        end
    end

    // shared iterative units for the end-of-run metrics
    always_comb begin
        div_start  = 1'b0;
        root_start = 1'b0;
        dividend   = r_abs_sum;
        radicand   = quotient;
        case (i_cmd.op)
            tfem_pkg::OP_DIV_L1: div_start = 1'b1;
            tfem_pkg::OP_DIV_SQ: begin
                div_start = 1'b1;
                dividend  = r_sq_sum;
            end
            tfem_pkg::OP_DIV_FO: begin
                div_start = 1'b1;
                dividend  = r_four_sum;
            end
            tfem_pkg::OP_ROOT_Q: root_start = 1'b1;
            tfem_pkg::OP_ROOT_S: begin
                root_start = 1'b1;
                radicand   = {16'd0, r_s, 16'd0};
            end
            default: ;
        endcase
    end

    tfem_div #(.DIVISOR_W(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    tfem_root u_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (root_start),
        .i_radicand (radicand),
        .o_done     (root_done),
        .o_root     (root)
    );

    assign o_sts.fit       = r_fit;
    assign o_sts.last      = r_last;
    assign o_sts.has_n     = (r_count != '0);
    assign o_sts.div_done  = div_done;
    assign o_sts.root_done = root_done;

    assign o_new_target    = r_o_new;
    assign o_error_value   = r_o_err;
    assign o_alter_model   = r_o_alter;
    assign o_metrics_valid = r_o_mval;
    assign o_rms_error     = r_o_rms;
    assign o_max_error     = r_o_max;
    assign o_l4_error      = r_o_l4;
    assign o_l1_error      = r_o_l1;
endmodule

>>> hdl/tfem_ctrl.sv
// Controller: sequences one sample through the datapath and the end-of-run metrics.
`timescale 1ns / 1ps
module tfem_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    input  tfem_pkg::t_sts  i_sts,
    output tfem_pkg::t_cmd  o_cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_MUL, S_FOUR, S_ACC, S_ACC2,
        S_DIV_L1, S_WAIT_L1, S_KEEP_L1,
        S_DIV_SQ, S_WAIT_DSQ, S_ROOT_SQ, S_WAIT_RSQ, S_KEEP_RMS,
        S_DIV_FO, S_WAIT_DFO, S_ROOT_FO, S_WAIT_RFO, S_KEEP_S,
        S_ROOT_S, S_WAIT_RS, S_KEEP_L4,
        S_OUT
    } t_state;

    t_state        r_state, n_state;
    tfem_pkg::t_op r_op, n_op;
    logic          r_out_valid;
    logic          load, out_load;

    assign load     = (r_state == S_IDLE) && i_in_valid;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_ERR;
            S_ERR:      n_state = S_MUL;
            S_MUL:      n_state = S_FOUR;
            S_FOUR:     n_state = S_ACC;
            S_ACC:      n_state = S_ACC2;
            S_ACC2:     n_state = (i_sts.fit && i_sts.last && i_sts.has_n) ? S_DIV_L1 : S_OUT;
            S_DIV_L1:   n_state = S_WAIT_L1;
            S_WAIT_L1:  if (i_sts.div_done) n_state = S_KEEP_L1;
            S_KEEP_L1:  n_state = S_DIV_SQ;
            S_DIV_SQ:   n_state = S_WAIT_DSQ;
            S_WAIT_DSQ: if (i_sts.div_done) n_state = S_ROOT_SQ;
            S_ROOT_SQ:  n_state = S_WAIT_RSQ;
            S_WAIT_RSQ: if (i_sts.root_done) n_state = S_KEEP_RMS;
            S_KEEP_RMS: n_state = S_DIV_FO;
            S_DIV_FO:   n_state = S_WAIT_DFO;
            S_WAIT_DFO: if (i_sts.div_done) n_state = S_ROOT_FO;
            S_ROOT_FO:  n_state = S_WAIT_RFO;
            S_WAIT_RFO: if (i_sts.root_done) n_state = S_KEEP_S;
            S_KEEP_S:   n_state = S_ROOT_S;
            S_ROOT_S:   n_state = S_WAIT_RS;
            S_WAIT_RS:  if (i_sts.root_done) n_state = S_KEEP_L4;
            S_KEEP_L4:  n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase

        case (n_state)
            S_ERR:      n_op = tfem_pkg::OP_ERR;
            S_MUL:      n_op = tfem_pkg::OP_MUL;
            S_FOUR:     n_op = tfem_pkg::OP_FOUR;
            S_ACC:      n_op = tfem_pkg::OP_ACC;
            S_ACC2:     n_op = tfem_pkg::OP_ACC2;
            S_DIV_L1:   n_op = tfem_pkg::OP_DIV_L1;
            S_KEEP_L1:  n_op = tfem_pkg::OP_KEEP_L1;
            S_DIV_SQ:   n_op = tfem_pkg::OP_DIV_SQ;
            S_ROOT_SQ:  n_op = tfem_pkg::OP_ROOT_Q;
            S_KEEP_RMS: n_op = tfem_pkg::OP_KEEP_RMS;
            S_DIV_FO:   n_op = tfem_pkg::OP_DIV_FO;
            S_ROOT_FO:  n_op = tfem_pkg::OP_ROOT_Q;
            S_KEEP_S:   n_op = tfem_pkg::OP_KEEP_S;
            S_ROOT_S:   n_op = tfem_pkg::OP_ROOT_S;
            S_KEEP_L4:  n_op = tfem_pkg::OP_KEEP_L4;
            default:    n_op = tfem_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= tfem_pkg::OP_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            if (out_load)         r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_cmd.op       = r_op;
    assign o_cmd.load     = load;
    assign o_cmd.out_load = out_load;
endmodule

>>> hdl/tfem_chk.sv
// Port-level assertions for the trace fit error metrics block, with bind.
`timescale 1ns / 1ps
module tfem_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        alter_model,
    input logic        metrics_valid,
    input logic [31:0] error_value,
    input logic [31:0] rms_error,
    input logic [31:0] max_error,
    input logic [31:0] l4_error,
    input logic [31:0] l1_error
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output transaction dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    a_metrics_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !metrics_valid |->
            rms_error == 32'd0 && max_error == 32'd0 && l4_error == 32'd0 && l1_error == 32'd0)
        else $error("metric fields nonzero outside last sample");

    a_record_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !alter_model |-> error_value == 32'd0)
        else $error("error reported in record mode");
endmodule

bind trace_fit_error_metrics tfem_chk u_tfem_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .in_valid      (i_in_ch.valid),
    .in_ready      (i_in_ch.ready),
    .out_valid     (o_out_ch.valid),
    .out_ready     (o_out_ch.ready),
    .alter_model   (o_out_ch.alter_model),
    .metrics_valid (o_out_ch.metrics_valid),
    .error_value   (o_out_ch.error_value),
    .rms_error     (o_out_ch.rms_error),
    .max_error     (o_out_ch.max_error),
    .l4_error      (o_out_ch.l4_error),
    .l1_error      (o_out_ch.l1_error)
);

>>> tb/sv/testbench.sv
// Self-checking testbench for the trace fit error metrics block.
`timescale 1ns / 1ps
module testbench;

    // Mode code 3 is not decoded by the block and must act as record.
    localparam logic [tfem_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int MAX_SAMPLES = 1048576;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic signed [31:0] new_target;
        logic signed [31:0] error_value;
        logic               alter_model;
        logic               metrics_valid;
        logic [31:0]        rms_error;
        logic [31:0]        max_error;
        logic [31:0]        l4_error;
        logic [31:0]        l1_error;
    } t_result;

    // One directed row: the settings it runs under, the sample, and, where the
    // answer is obvious, the result typed in by hand.
    typedef struct packed {
        logic [tfem_pkg::MODE_W-1:0] mode;
        logic [15:0]        gain;
        logic [15:0]        hold;
        logic signed [31:0] target;
        logic signed [31:0] trace;
        logic               last;
        logic               typed;
        t_result            answer;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tfem_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [tfem_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    tfem_in_if  in_ch ();
    tfem_out_if out_ch ();

    trace_fit_error_metrics u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: settings and run state as the block keeps them
    // ------------------------------------------------------------------
    logic [tfem_pkg::MODE_W-1:0] cfg_mode = tfem_pkg::MODE_RECORD;
    logic [15:0]       cfg_gain = '0;
    logic [15:0]       cfg_hold = '0;

    logic [63:0] abs_sum, sq_sum, quad_sum;
    logic [31:0] peak_mag;
    logic [20:0] fit_count;
    logic [15:0] held_count;

    t_result pending_results[$];
    int      mismatches = 0;
    int      results_seen = 0;

    function automatic logic signed [31:0] clip32(logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Bit-by-bit integer square root, floor.
    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] trial;
        r = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = r | (64'd1 << i);
            if (trial * trial <= x)
                r = trial;
        end
        return r;
    endfunction

    function automatic void clear_run();
        abs_sum = '0;
        sq_sum = '0;
        quad_sum = '0;
        peak_mag = '0;
        fit_count = '0;
        held_count = '0;
    endfunction

    function automatic t_result fit_sample(logic signed [31:0] tgt, logic signed [31:0] trc,
                                           logic last);
        t_result r;
        logic signed [63:0] t64, c64, prod, corr;
        logic [63:0] mag, sq, quad, n, s;
        logic [127:0] wide;
        r = '0;
        r.new_target = tgt;
        if (cfg_mode == tfem_pkg::MODE_CLAMP) begin
            r.new_target  = trc;
            r.alter_model = 1'b1;
        end else if (cfg_mode == tfem_pkg::MODE_FIT) begin
            r.alter_model = 1'b1;
            t64 = tgt;
            c64 = trc;
            r.error_value = clip32(t64 - c64);
            if (held_count < cfg_hold) begin
                held_count++;
            end else begin
                prod = 64'(r.error_value) * $signed({48'd0, cfg_gain});
                corr = (prod + 64'sd32768) >>> 16;
                r.new_target = clip32(t64 - corr);
            end
            mag  = r.error_value[31] ? 64'(-64'(r.error_value)) : 64'(r.error_value);
            sq   = mag * mag;
            wide = {64'd0, sq} * {64'd0, sq};
            quad = (wide[127:96] != 0) ? '1 : wide[95:32];
            abs_sum  = add_clip(abs_sum, mag);
            sq_sum   = add_clip(sq_sum, sq);
            quad_sum = add_clip(quad_sum, quad);
            if (mag > peak_mag)
                peak_mag = mag[31:0];
            if (fit_count < MAX_SAMPLES)
                fit_count++;
        end
        if (last) begin
            r.metrics_valid = 1'b1;
            if (cfg_mode == tfem_pkg::MODE_FIT && fit_count != 0) begin
                n = 64'(fit_count);
                r.l1_error  = 32'(abs_sum / n);
                r.rms_error = 32'(int_root(sq_sum / n));
                s = int_root(quad_sum / n);
                r.l4_error  = 32'(int_root(s << 16));
                r.max_error = peak_mag;
            end
            clear_run();
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic send_sample(logic signed [31:0] tgt, logic signed [31:0] trc, logic last,
                               logic typed, t_result answer);
        t_result guess;
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 10);
        end
        in_ch.valid        <= 1'b1;
        in_ch.target_value <= tgt;
        in_ch.trace_value  <= trc;
        in_ch.last_sample  <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
        guess = fit_sample(tgt, trc, last);
        pending_results.push_back(typed ? answer : guess);
    endtask

    // Hold the input side until every expected transaction has come out.
    task automatic drain();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [tfem_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tfem_pkg::REG_ACTION_MODE:     cfg_mode = data[tfem_pkg::MODE_W-1:0];
            tfem_pkg::REG_CORRECTION_GAIN: cfg_gain = data;
            tfem_pkg::REG_WAIT_SAMPLES:    cfg_hold = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [tfem_pkg::MODE_W-1:0] mode, logic [15:0] gain,
                             logic [15:0] hold);
        drain();
        write_reg(tfem_pkg::REG_ACTION_MODE, 16'(mode));
        write_reg(tfem_pkg::REG_CORRECTION_GAIN, gain);
        write_reg(tfem_pkg::REG_WAIT_SAMPLES, hold);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall pattern that is redrawn periodically, plus one long hold
    // ------------------------------------------------------------------
    int  rx_cycle = 0;
    int  hold_left = 0;
    bit  held_once = 0;
    int  stall_pct = 0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 64 == 0)
            stall_pct <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
        if (!held_once && results_seen >= 150 && in_ch.valid) begin
            // Hold off long enough for the block to back up into its input.
            held_once <= 1'b1;
            hold_left <= 300;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.new_target    = out_ch.new_target;
            got.error_value   = out_ch.error_value;
            got.alter_model   = out_ch.alter_model;
            got.metrics_valid = out_ch.metrics_valid;
            got.rms_error     = out_ch.rms_error;
            got.max_error     = out_ch.max_error;
            got.l4_error      = out_ch.l4_error;
            got.l1_error      = out_ch.l1_error;
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("ERROR: unexpected result transaction %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("ERROR: result %0d\n  expected %p\n  actual   %p",
                                 results_seen, want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    localparam logic signed [31:0] VMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VMIN = 32'sh80000000;

    function automatic t_result typed_result(logic signed [31:0] nt, logic signed [31:0] ev,
                                             logic alter, logic last);
        t_result r;
        r = '0;
        r.new_target    = nt;
        r.error_value   = ev;
        r.alter_model   = alter;
        r.metrics_valid = last;
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return VMAX;
            1:       return VMIN;
            2:       return 32'($urandom_range(0, 1) ? 32'sd0 : -32'sd1);
            default: return $urandom;
        endcase
    endfunction

    t_row rows[$];

    initial begin
        t_row row;
        logic [tfem_pkg::MODE_W-1:0] mode;
        logic [15:0] gain, hold;
        logic signed [31:0] tgt, trc;
        int sent, run_len, span;

        in_ch.valid        = 1'b0;
        in_ch.target_value = '0;
        in_ch.trace_value  = '0;
        in_ch.last_sample  = 1'b0;
        clear_run();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: reset defaults first, then each mode and its corners.
        rows.push_back({tfem_pkg::MODE_RECORD, 16'd0, 16'd0, VMAX, VMIN, 1'b0, 1'b1,
                        typed_result(VMAX, 32'sd0, 1'b0, 1'b0)});
        rows.push_back({tfem_pkg::MODE_RECORD, 16'd0, 16'd0, VMIN, VMAX, 1'b1, 1'b1,
                        typed_result(VMIN, 32'sd0, 1'b0, 1'b1)});
        rows.push_back({MODE_SPARE, 16'd0, 16'd0, 32'sd5, 32'sd7, 1'b1, 1'b1,
                        typed_result(32'sd5, 32'sd0, 1'b0, 1'b1)});
        rows.push_back({tfem_pkg::MODE_CLAMP, 16'd0, 16'd0, 32'sd1, VMIN, 1'b0, 1'b1,
                        typed_result(VMIN, 32'sd0, 1'b1, 1'b0)});
        rows.push_back({tfem_pkg::MODE_CLAMP, 16'd0, 16'd0, VMIN, VMAX, 1'b1, 1'b1,
                        typed_result(VMAX, 32'sd0, 1'b1, 1'b1)});
        // Fit with zero gain: error saturates both ways, the model is kept.
        rows.push_back({tfem_pkg::MODE_FIT, 16'd0, 16'd0, VMAX, VMIN, 1'b0, 1'b1,
                        typed_result(VMAX, VMAX, 1'b1, 1'b0)});
        rows.push_back({tfem_pkg::MODE_FIT, 16'd0, 16'd0, VMIN, VMAX, 1'b1, 1'b0,
                        t_result'('0)});
        // Zero error run: every metric is zero.
        rows.push_back({tfem_pkg::MODE_FIT, 16'd0, 16'd0, 32'sh1234, 32'sh1234, 1'b1, 1'b1,
                        typed_result(32'sh1234, 32'sd0, 1'b1, 1'b1)});
        // Full gain, both error signs and saturated errors.
        rows.push_back({tfem_pkg::MODE_FIT, 16'hFFFF, 16'd0, VMAX, VMIN, 1'b0, 1'b0,
                        t_result'('0)});
        rows.push_back({tfem_pkg::MODE_FIT, 16'hFFFF, 16'd0, VMIN, VMAX, 1'b0, 1'b0,
                        t_result'('0)});
        rows.push_back({tfem_pkg::MODE_FIT, 16'hFFFF, 16'd0, 32'sh00018000, 32'sh00010000,
                        1'b0, 1'b0, t_result'('0)});
        rows.push_back({tfem_pkg::MODE_FIT, 16'hFFFF, 16'd0, -32'sd3, 32'sd1, 1'b1, 1'b0,
                        t_result'('0)});
        // Start-of-run wait: two samples uncorrected, then correction starts.
        for (int i = 0; i < 4; i++)
            rows.push_back({tfem_pkg::MODE_FIT, 16'h8000, 16'd2, 32'(i * 70000),
                            -32'sd12345, 1'(i == 3), 1'b0, t_result'('0)});
        // A config write does not disturb the run in progress.
        rows.push_back({tfem_pkg::MODE_FIT, 16'h0001, 16'hFFFF, 32'sh00050000, 32'sd0,
                        1'b0, 1'b0, t_result'('0)});
        rows.push_back({tfem_pkg::MODE_FIT, 16'h7FFF, 16'd0, 32'sh00050000, 32'sd0,
                        1'b1, 1'b0, t_result'('0)});
        // Non-fit last sample clears the fit state left behind.
        rows.push_back({tfem_pkg::MODE_FIT, 16'h4000, 16'd0, 32'sd100, 32'sd0, 1'b0, 1'b0,
                        t_result'('0)});
        rows.push_back({tfem_pkg::MODE_RECORD, 16'h4000, 16'd0, 32'sd9, 32'sd1, 1'b1, 1'b1,
                        typed_result(32'sd9, 32'sd0, 1'b0, 1'b1)});
        rows.push_back({tfem_pkg::MODE_FIT, 16'h4000, 16'd0, 32'sd0, 32'sd0, 1'b1, 1'b1,
                        typed_result(32'sd0, 32'sd0, 1'b1, 1'b1)});

        foreach (rows[i]) begin
            row = rows[i];
            // The first row runs on reset values, so no write is needed there.
            if (row.mode != cfg_mode || row.gain != cfg_gain || row.hold != cfg_hold)
                configure(row.mode, row.gain, row.hold);
            send_sample(row.target, row.trace, row.last, row.typed, row.answer);
        end

        // Random runs: mostly fit, each ending on a last sample.
        sent = 0;
        for (int ph = 0; sent < 550; ph++) begin
            case ($urandom_range(0, 9))
                0:       mode = tfem_pkg::MODE_RECORD;
                1:       mode = tfem_pkg::MODE_CLAMP;
                2:       mode = MODE_SPARE;
                default: mode = tfem_pkg::MODE_FIT;
            endcase
            case (ph % 4)
                0:       gain = 16'hFFFF;
                1:       gain = 16'h0000;
                default: gain = 16'($urandom);
            endcase
            case ($urandom_range(0, 7))
                0:       hold = 16'hFFFF;
                1, 2:    hold = 16'($urandom_range(1, 5));
                default: hold = '0;
            endcase
            configure(mode, gain, hold);
            for (int r = 0; r < 6 && sent < 550; r++) begin
                run_len = $urandom_range(1, 14);
                span = $urandom_range(0, 1) ? 16 : 28;
                for (int k = 0; k < run_len; k++) begin
                    if ($urandom_range(0, 9) < 6) begin
                        // Trace near the model, as in a real fit.
                        trc = $urandom;
                        tgt = trc + $signed(32'($urandom_range(0, 1 << span))
                                            - 32'(1 << (span - 1)));
                    end else begin
                        tgt = pick_value();
                        trc = pick_value();
                    end
                    send_sample(tgt, trc, k == run_len - 1, 1'b0, t_result'('0));
                    sent++;
                end
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
hdl/tfem_pkg.sv
hdl/tfem_in_if.sv
hdl/tfem_out_if.sv
hdl/tfem_div.sv
hdl/tfem_root.sv
hdl/tfem_dp.sv
hdl/tfem_ctrl.sv
hdl/trace_fit_error_metrics.sv
hdl/tfem_chk.sv
tb/sv/testbench.sv
